/* design/erm_pkg.sv */
// ----------------------------------------------------------------------------
// erm_pkg: shared types, constants and helpers for the rotation matrix unit
// Fixed-point constants (Q30), reciprocal factors for the small polynomial
// divisors, rounding helpers and the axis rotation builder.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 15;
  localparam int ENTRY_FRAC_BITS_DEF = 15;

  // Pipeline depth of the sine/cosine unit and of the matrix section.
  localparam int SC_STAGES  = 13;
  localparam int MAT_STAGES = 5;

  // Angle constants in Q30.
  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [32:0] QTR_PI_Q30  = 33'(HALF_PI_Q30 / 2);
  localparam logic [32:0] Q_TH1 = HALF_PI_Q30 - QTR_PI_Q30;
  localparam logic [32:0] Q_TH2 = 33'(HALF_PI_Q30 * 2) - QTR_PI_Q30;
  localparam logic [32:0] Q_TH3 = 33'(HALF_PI_Q30 * 3) - QTR_PI_Q30;
  localparam logic [32:0] Q_TH4 = 33'(HALF_PI_Q30 * 4) - QTR_PI_Q30;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Reciprocals scaled by 2^RCP_SHIFT for division by small constants.
  localparam int RCP_SHIFT = 34;
  localparam logic [31:0] RCP_42 = 32'((64'd1 << RCP_SHIFT) / 42);
  localparam logic [31:0] RCP_56 = 32'((64'd1 << RCP_SHIFT) / 56);
  localparam logic [31:0] RCP_20 = 32'((64'd1 << RCP_SHIFT) / 20);
  localparam logic [31:0] RCP_30 = 32'((64'd1 << RCP_SHIFT) / 30);
  localparam logic [31:0] RCP_6  = 32'((64'd1 << RCP_SHIFT) / 6);
  localparam logic [31:0] RCP_12 = 32'((64'd1 << RCP_SHIFT) / 12);

  typedef logic signed [31:0] q30_t;
  typedef q30_t mat_t [3][3];

  typedef enum logic [1:0] {
    ORD_ZYX = 2'd0,
    ORD_XYZ = 2'd1,
    ORD_XZY = 2'd2,
    ORD_BAD = 2'd3
  } order_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  // Finishes a reciprocal division: the estimate is the true quotient or one
  // below it, so a single remainder compare corrects it.
  function automatic logic [29:0] div_fix(input logic [29:0] v, input logic [61:0] p,
                                          input logic [5:0] d);
    logic [27:0] q0;
    logic [30:0] r;
    q0 = p[61:34];
    r = 31'(v) - 31'(q0) * 31'(d);
    div_fix = 30'(q0) + 30'(r >= 31'(d));
  endfunction

  // Arithmetic shift right by d with rounding half away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int d);
    logic signed [63:0] h;
    h = 64'sd1 <<< (d - 1);
    rnd_shift = (v + h - (v[63] ? 64'sd1 : 64'sd0)) >>> d;
  endfunction

  // Right-handed rotation about one axis.
  function automatic mat_t rot_mat(input axis_t a, input q30_t s, input q30_t c);
    mat_t m;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = (i == j) ? q30_t'(32'(Q30_ONE)) : '0;
      end
    end
    unique case (a)
      AX_X: begin
        m[1][1] = c; m[1][2] = -s; m[2][1] = s; m[2][2] = c;
      end
      AX_Y: begin
        m[0][0] = c; m[0][2] = s; m[2][0] = -s; m[2][2] = c;
      end
      AX_Z: begin
        m[0][0] = c; m[0][1] = -s; m[1][0] = s; m[1][1] = c;
      end
      default: begin
      end
    endcase
    return m;
  endfunction

endpackage

/* design/euler_rotation_matrix_unit.sv */
// ----------------------------------------------------------------------------
// euler_rotation_matrix_unit: Euler-angle rotation matrix generator
// Builds the 3x3 rotation matrix for one of three composition orders and
// sends it out as three row beats, or as one zero beat for an invalid order.
// ----------------------------------------------------------------------------
// A beat on the input carries three angles and an order code; the matrix
// leaves as rows 0, 1 and 2, the last one flagged, or as a single zero beat
// with bad_order set for the invalid code. The pipeline takes a new item in
// every cycle it is not held; the output port sends the three row beats of
// an item (one beat for invalid codes) before the last stage takes the next
// item, and holds the pipeline meanwhile. Thirteen stages compute sine and
// cosine for all three angles in parallel, and five more do the two matrix
// products, the rounding and the saturation. Earlier stages keep filling
// while the output waits.
module euler_rotation_matrix_unit import erm_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int ENTRY_FRAC_BITS = ENTRY_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [17:0] in_angle_x,
  input  logic signed [17:0] in_angle_y,
  input  logic signed [17:0] in_angle_z,
  input  logic [1:0]         in_order,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_row_index,
  output logic signed [16:0] out_col_zero,
  output logic signed [16:0] out_col_one,
  output logic signed [16:0] out_col_two,
  output logic               out_last_row,
  output logic               out_bad_order
);

  localparam int NSTG = SC_STAGES + MAT_STAGES;
  localparam int P1   = SC_STAGES;
  localparam int S1   = SC_STAGES + 1;
  localparam int P2   = SC_STAGES + 2;
  localparam int S2   = SC_STAGES + 3;
  localparam int ES   = SC_STAGES + 4;

  logic [NSTG:0]   en;
  logic [NSTG-1:0] v_r;
  order_t          ord_r [NSTG];
  logic [1:0]      row_r;
  logic            take, last_beat, bad;

  q30_t sx, cx, sy, cy, sz, cz;

  logic signed [63:0] p1_r [3][3][3];
  logic signed [63:0] p2_r [3][3][3];
  q30_t               t_r  [3][3];
  q30_t               m_r  [3][3];
  q30_t               sc_r [2][6];
  logic [16:0]        ent_r [3][3];

  // Output side: the last stage holds an item until all its rows are taken.
  assign out_valid = v_r[ES];
  assign bad       = (ord_r[ES] == ORD_BAD);
  assign last_beat = bad || (row_r == 2'd2);
  assign take      = out_valid && out_ready;

  // Stage enables: a stage loads when it is empty or its successor moves.
  always_comb begin
    en[NSTG] = take && last_beat;
    for (int i = NSTG - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end
  assign in_ready = en[0];

  // Valid bits and row counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      row_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
      if (take) begin
        row_r <= last_beat ? 2'd0 : row_r + 2'd1;
      end
    end
  end

  // Order code travels with the item.
  always_ff @(posedge clk) begin
    if (en[0]) ord_r[0] <= order_t'(in_order);
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) ord_r[i] <= ord_r[i-1];
    end
  end

  // Sine and cosine of the three angles.
  erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_x (
    .clk(clk), .en(en[SC_STAGES-1:0]), .angle(in_angle_x), .sin_o(sx), .cos_o(cx)
  );
  erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_y (
    .clk(clk), .en(en[SC_STAGES-1:0]), .angle(in_angle_y), .sin_o(sy), .cos_o(cy)
  );
  erm_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_z (
    .clk(clk), .en(en[SC_STAGES-1:0]), .angle(in_angle_z), .sin_o(sz), .cos_o(cz)
  );

  // Operands of the first product, chosen by order.
  mat_t mat_a, mat_b, mat_c;
  always_comb begin
    unique case (ord_r[P1-1])
      ORD_XYZ: begin
        mat_a = rot_mat(AX_X, sx, cx);
        mat_b = rot_mat(AX_Y, sy, cy);
      end
      ORD_XZY: begin
        mat_a = rot_mat(AX_X, sx, cx);
        mat_b = rot_mat(AX_Z, sz, cz);
      end
      default: begin
        mat_a = rot_mat(AX_Z, sz, cz);
        mat_b = rot_mat(AX_Y, sy, cy);
      end
    endcase
  end

  // Third factor, from the carried sine and cosine values.
  always_comb begin
    unique case (ord_r[P2-1])
      ORD_XYZ: mat_c = rot_mat(AX_Z, sc_r[1][4], sc_r[1][5]);
      ORD_XZY: mat_c = rot_mat(AX_Y, sc_r[1][2], sc_r[1][3]);
      default: mat_c = rot_mat(AX_X, sc_r[1][0], sc_r[1][1]);
    endcase
  end

  // Entry rounding and saturation.
  logic signed [63:0] ent_w [3][3];
  logic signed [63:0] lim;
  always_comb begin
    lim = 64'sd1 <<< ENTRY_FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ent_w[i][j] = rnd_shift(64'(m_r[i][j]), 30 - ENTRY_FRAC_BITS);
        if (ent_w[i][j] > lim) ent_w[i][j] = lim;
        else if (ent_w[i][j] < -lim) ent_w[i][j] = -lim;
      end
    end
  end

  // Matrix stages: products, rounded sums, second product, entries.
  always_ff @(posedge clk) begin
    if (en[P1]) begin
      sc_r[0] <= '{sx, cx, sy, cy, sz, cz};
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            p1_r[i][j][k] <= mat_a[i][k] * mat_b[k][j];
    end
    if (en[S1]) begin
      sc_r[1] <= sc_r[0];
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          t_r[i][j] <= 32'(rnd_shift(p1_r[i][j][0] + p1_r[i][j][1] + p1_r[i][j][2], 30));
    end
    if (en[P2]) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++)
            p2_r[i][j][k] <= t_r[i][k] * mat_c[k][j];
    end
    if (en[S2]) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m_r[i][j] <= 32'(rnd_shift(p2_r[i][j][0] + p2_r[i][j][1] + p2_r[i][j][2], 30));
    end
    if (en[ES]) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          ent_r[i][j] <= ent_w[i][j][16:0];
    end
  end

  // Row beat selection.
  assign out_row_index = row_r;
  assign out_col_zero  = bad ? '0 : $signed(ent_r[row_r][0]);
  assign out_col_one   = bad ? '0 : $signed(ent_r[row_r][1]);
  assign out_col_two   = bad ? '0 : $signed(ent_r[row_r][2]);
  assign out_last_row  = last_beat;
  assign out_bad_order = bad;

endmodule

/* design/erm_sincos.sv */
// ----------------------------------------------------------------------------
// erm_sincos: pipelined sine and cosine of one fixed-point angle
// Range reduction, quadrant split and Taylor polynomials in Q30, thirteen
// register stages, each advanced by its own enable.
// ----------------------------------------------------------------------------
module erm_sincos import erm_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic [SC_STAGES-1:0]  en,
  input  logic signed [17:0]    angle,
  output q30_t                  sin_o,
  output q30_t                  cos_o
);

  localparam int SHIFT     = 30 - ANGLE_FRAC_BITS;
  localparam int MAG_W     = 48 - ANGLE_FRAC_BITS;
  localparam int UW        = (MAG_W > 34) ? MAG_W : 34;
  localparam int MOD_STEPS = (ANGLE_FRAC_BITS >= 15) ? 1 : 16 - ANGLE_FRAC_BITS;

  // Carried fields, one register per stage.
  logic        neg_r  [0:11];
  logic        xneg_r [1:11];
  logic [1:0]  q_r    [1:11];
  logic [29:0] ax_r   [1:10];
  logic [29:0] x2_r   [2:10];

  logic [32:0] u0_r;
  logic [61:0] ps3_r, pc3_r, ps6_r, pc6_r, ps9_r, pc9_r;
  logic [30:0] ts4_r, tc4_r, ts7_r, tc7_r, ts10_r, tc10_r;
  logic [29:0] ms5_r, mc5_r, ms6_r, mc6_r, ms8_r, mc8_r, ms9_r, mc9_r;
  logic [29:0] s11_r, mc11_r;
  q30_t        sin12_r, cos12_r;

  // Stage 0: magnitude, scale to Q30 and reduce modulo two pi.
  logic          angle_neg;
  logic [17:0]   mag;
  logic [UW-1:0] u_acc;
  always_comb begin
    angle_neg = angle[17];
    mag = angle_neg ? 18'(-angle) : 18'(angle);
    u_acc = UW'(mag) << SHIFT;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (u_acc >= (UW'(TWO_PI_Q30) << k)) begin
        u_acc = u_acc - (UW'(TWO_PI_Q30) << k);
      end
    end
  end

  // Stage 1: quadrant and residual angle.
  logic [2:0]         q_sel;
  logic signed [34:0] x_s;
  logic [29:0]        ax1;
  always_comb begin
    priority if (u0_r >= Q_TH4) q_sel = 3'd4;
    else if (u0_r >= Q_TH3)     q_sel = 3'd3;
    else if (u0_r >= Q_TH2)     q_sel = 3'd2;
    else if (u0_r >= Q_TH1)     q_sel = 3'd1;
    else                        q_sel = 3'd0;
    x_s = $signed({2'b00, u0_r}) - $signed(35'(q_sel) * 35'(HALF_PI_Q30));
    ax1 = x_s[34] ? 30'(-x_s) : 30'(x_s);
  end

  // Polynomial products.
  logic [59:0] sq2;
  logic [60:0] pr5s, pr5c, pr8s, pr8c, pr11s, pr11c;
  always_comb begin
    sq2   = 60'(ax_r[1]) * 60'(ax_r[1]) + 60'h2000_0000;
    pr5s  = 61'(x2_r[4]) * 61'(ts4_r);
    pr5c  = 61'(x2_r[4]) * 61'(tc4_r);
    pr8s  = 61'(x2_r[7]) * 61'(ts7_r);
    pr8c  = 61'(x2_r[7]) * 61'(tc7_r);
    pr11s = 61'(ax_r[10]) * 61'(ts10_r);
    pr11c = 61'(x2_r[10]) * 61'(tc10_r);
  end

  // Stage 12: cosine tail, quadrant mapping and angle sign.
  logic [30:0] c_mag;
  q30_t        s_val, c_val, rs, rc;
  always_comb begin
    c_mag = Q30_ONE - 31'(mc11_r >> 1);
    s_val = xneg_r[11] ? -$signed({2'b00, s11_r}) : $signed({2'b00, s11_r});
    c_val = $signed({1'b0, c_mag});
    unique case (q_r[11])
      2'd0: begin rs = s_val;  rc = c_val;  end
      2'd1: begin rs = c_val;  rc = -s_val; end
      2'd2: begin rs = -s_val; rc = -c_val; end
      2'd3: begin rs = -c_val; rc = s_val;  end
    endcase
  end

  // Carried fields move with their stage enables.
  always_ff @(posedge clk) begin
    if (en[0]) neg_r[0] <= angle_neg;
    for (int k = 1; k <= 11; k++) begin
      if (en[k]) neg_r[k] <= neg_r[k-1];
    end
    if (en[1]) begin
      xneg_r[1] <= x_s[34];
      q_r[1]    <= q_sel[1:0];
      ax_r[1]   <= ax1;
    end
    for (int k = 2; k <= 11; k++) begin
      if (en[k]) begin
        xneg_r[k] <= xneg_r[k-1];
        q_r[k]    <= q_r[k-1];
      end
    end
    for (int k = 2; k <= 10; k++) begin
      if (en[k]) ax_r[k] <= ax_r[k-1];
    end
    if (en[2]) x2_r[2] <= sq2[59:30];
    for (int k = 3; k <= 10; k++) begin
      if (en[k]) x2_r[k] <= x2_r[k-1];
    end
  end

  // Arithmetic stages.
  always_ff @(posedge clk) begin
    if (en[0]) u0_r <= u_acc[32:0];
    if (en[3]) begin
      ps3_r <= 62'(x2_r[2]) * 62'(RCP_42);
      pc3_r <= 62'(x2_r[2]) * 62'(RCP_56);
    end
    if (en[4]) begin
      ts4_r <= Q30_ONE - 31'(div_fix(x2_r[3], ps3_r, 6'd42));
      tc4_r <= Q30_ONE - 31'(div_fix(x2_r[3], pc3_r, 6'd56));
    end
    if (en[5]) begin
      ms5_r <= pr5s[59:30];
      mc5_r <= pr5c[59:30];
    end
    if (en[6]) begin
      ps6_r <= 62'(ms5_r) * 62'(RCP_20);
      pc6_r <= 62'(mc5_r) * 62'(RCP_30);
      ms6_r <= ms5_r;
      mc6_r <= mc5_r;
    end
    if (en[7]) begin
      ts7_r <= Q30_ONE - 31'(div_fix(ms6_r, ps6_r, 6'd20));
      tc7_r <= Q30_ONE - 31'(div_fix(mc6_r, pc6_r, 6'd30));
    end
    if (en[8]) begin
      ms8_r <= pr8s[59:30];
      mc8_r <= pr8c[59:30];
    end
    if (en[9]) begin
      ps9_r <= 62'(ms8_r) * 62'(RCP_6);
      pc9_r <= 62'(mc8_r) * 62'(RCP_12);
      ms9_r <= ms8_r;
      mc9_r <= mc8_r;
    end
    if (en[10]) begin
      ts10_r <= Q30_ONE - 31'(div_fix(ms9_r, ps9_r, 6'd6));
      tc10_r <= Q30_ONE - 31'(div_fix(mc9_r, pc9_r, 6'd12));
    end
    if (en[11]) begin
      s11_r  <= pr11s[59:30];
      mc11_r <= pr11c[59:30];
    end
    if (en[12]) begin
      sin12_r <= neg_r[11] ? -rs : rs;
      cos12_r <= rc;
    end
  end

  assign sin_o = sin12_r;
  assign cos_o = cos12_r;

endmodule

/* design/erm_checker.sv */
// ----------------------------------------------------------------------------
// erm_checker: port-level checks for the rotation matrix unit
// Watches the input beats and the row beats of the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module erm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [17:0] in_angle_x,
  input logic signed [17:0] in_angle_y,
  input logic signed [17:0] in_angle_z,
  input logic [1:0]         in_order,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_row_index,
  input logic signed [16:0] out_col_zero,
  input logic signed [16:0] out_col_one,
  input logic signed [16:0] out_col_two,
  input logic               out_last_row,
  input logic               out_bad_order
);

  // A waiting input beat keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_angle_x) &&
    $stable(in_angle_y) && $stable(in_angle_z) && $stable(in_order))
    else $error("input beat changed while waiting");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index) &&
    $stable(out_col_zero) && $stable(out_col_one) && $stable(out_col_two) &&
    $stable(out_last_row) && $stable(out_bad_order))
    else $error("result beat changed while stalled");

  // An invalid order gives one zero beat for row 0.
  a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_order |-> out_last_row && out_row_index == 2'd0 &&
    out_col_zero == 17'sd0 && out_col_one == 17'sd0 && out_col_two == 17'sd0)
    else $error("bad order beat malformed");

  // Rows of one matrix follow each other without a gap.
  a_row_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_row |=>
    out_valid && !out_bad_order && out_row_index == $past(out_row_index) + 2'd1)
    else $error("row sequence broken");

  // A valid matrix ends exactly at row 2.
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_order |-> out_last_row == (out_row_index == 2'd2))
    else $error("last row flag misplaced");

endmodule

bind euler_rotation_matrix_unit erm_checker u_erm_checker (.*);
